@@ rtl/kwlex_pkg.sv @@
// kwlex_pkg: token codes, scanner modes, result record and keyword table
// for the keyword lexer; no dependencies
package kwlex_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned KwCount    = 12;

  typedef enum logic [2:0] {
    ModeIdle  = 3'd0,
    ModeWord  = 3'd1,
    ModeNum   = 3'd2,
    ModeColon = 3'd3,
    ModeLt    = 3'd4,
    ModeGt    = 3'd5,
    ModeEq    = 3'd6,
    ModeBang  = 3'd7
  } scan_mode_e;

  localparam logic [4:0] TokIdent   = 5'd0;
  localparam logic [4:0] TokNumber  = 5'd1;
  localparam logic [4:0] TokKwFirst = 5'd2;
  localparam logic [4:0] TokAssign  = 5'd14;
  localparam logic [4:0] TokLe      = 5'd15;
  localparam logic [4:0] TokGe      = 5'd16;
  localparam logic [4:0] TokEq      = 5'd17;
  localparam logic [4:0] TokNe      = 5'd18;
  localparam logic [4:0] TokLt      = 5'd19;
  localparam logic [4:0] TokGt      = 5'd20;
  localparam logic [4:0] TokPlus    = 5'd21;
  localparam logic [4:0] TokMinus   = 5'd22;
  localparam logic [4:0] TokMul     = 5'd23;
  localparam logic [4:0] TokDiv     = 5'd24;
  localparam logic [4:0] TokSemi    = 5'd25;
  localparam logic [4:0] TokLpar    = 5'd26;
  localparam logic [4:0] TokRpar    = 5'd27;
  localparam logic [4:0] TokEnd     = 5'd28;
  localparam logic [4:0] TokError   = 5'd29;

  // keyword spelling, string literal order (first char in the highest used byte)
  localparam logic [39:0] KwStr [KwCount] = '{
    "start", "stop", "if", "then", "else", "end",
    "while", "do", "for", "to", "read", "print"
  };
  localparam logic [3:0] KwLen [KwCount] = '{
    4'd5, 4'd4, 4'd2, 4'd4, 4'd4, 4'd3, 4'd5, 4'd2, 4'd3, 4'd2, 4'd4, 4'd5
  };

  typedef struct packed {
    logic [4:0]  code;
    logic [3:0]  len;
    logic [63:0] text;
    logic        trunc;
    logic        last;
  } result_t;

  // case-insensitive keyword lookup on zero-padded text, first char lowest
  function automatic logic [4:0] kw_code(input logic [63:0] txt, input logic [3:0] len);
    logic [63:0] low;
    logic [63:0] expect_txt;
    logic [7:0]  b;
    logic [4:0]  code;
    code = TokIdent;
    for (int i = 0; i < 8; i++) begin
      b = txt[8*i +: 8];
      low[8*i +: 8] = (b >= 8'h41 && b <= 8'h5A) ? (b | 8'h20) : b;
    end
    for (int k = 0; k < KwCount; k++) begin
      expect_txt = '0;
      for (int i = 0; i < 5; i++) begin
        if (i < int'(KwLen[k])) begin
          expect_txt[8*i +: 8] = KwStr[k][8*(int'(KwLen[k]) - 1 - i) +: 8];
        end
      end
      if (len == KwLen[k] && low == expect_txt) begin
        code = TokKwFirst + 5'(k);
      end
    end
    return code;
  endfunction

endpackage

@@ rtl/keyword_lexer_unit.sv @@
// keyword_lexer_unit: streaming lexer, one character beat in, token beats out
// depends on kwlex_pkg
// a token enters the result queue as the beat that completes it is accepted and is offered once at the queue head
// throughput: one character per cycle while input is ready; one beat may yield two tokens, which
// a four-entry result queue absorbs (input ready while at most two are queued)
// reset: scanner idle, lexeme count and overflow cleared, result queue empty
module keyword_lexer_unit import kwlex_pkg::*; #(
  parameter int unsigned MaxLen = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic        s_axis_tuser,   // [0] end_of_input
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // [4:0] token_code, [8:5] lexeme_length,
                                      // [72:9] lexeme_text, [73] truncated, rest 0
  output logic        m_axis_tlast    // last_token
);

  localparam int unsigned CntW = $clog2(MaxLen + 1);
  localparam int unsigned IdxW = $clog2(MaxLen);
  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned FillW = $clog2(QueueDepth + 1);

  scan_mode_e       mode_q, mode_d;
  logic [7:0]       store_q [MaxLen];
  logic [CntW-1:0]  count_q, count_d;
  logic             ovf_q, ovf_d;

  result_t          queue_q [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FillW-1:0] fill_q;

  logic       accept, pop;
  logic [7:0] c;
  logic       eoi, is_sp, is_al, is_dg;

  // idle scan of the current beat
  logic        idle_emit;
  logic [4:0]  idle_code;
  logic [3:0]  idle_len;
  logic        idle_start;
  scan_mode_e  idle_mode;

  // pending token closed by the current beat
  logic        pend_emit, pend_rescan;
  result_t     pend_res, idle_res;
  logic        do_append, do_start;
  logic [63:0] packed_text;
  logic [1:0]  push_n;
  result_t     slot_a, slot_b;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign pop    = m_axis_tvalid && m_axis_tready;
  assign c      = s_axis_tdata;
  assign eoi    = s_axis_tuser;
  assign is_sp  = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  assign is_dg  = (c >= 8'h30 && c <= 8'h39);
  assign is_al  = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);

  always_comb begin
    packed_text = '0;
    for (int i = 0; i < MaxLen; i++) begin
      if (CntW'(i) < count_q) begin
        packed_text[8*i +: 8] = store_q[i];
      end
    end
  end

  always_comb begin
    idle_emit  = 1'b0;
    idle_code  = TokError;
    idle_len   = 4'd1;
    idle_start = 1'b0;
    idle_mode  = ModeIdle;
    if (eoi) begin
      idle_emit = 1'b1;
      idle_code = TokEnd;
      idle_len  = 4'd0;
    end else if (is_sp) begin
      idle_emit = 1'b0;
    end else if (is_al) begin
      idle_start = 1'b1;
      idle_mode  = ModeWord;
    end else if (is_dg) begin
      idle_start = 1'b1;
      idle_mode  = ModeNum;
    end else begin
      unique case (c)
        8'h3A: idle_mode = ModeColon;
        8'h3C: idle_mode = ModeLt;
        8'h3E: idle_mode = ModeGt;
        8'h3D: idle_mode = ModeEq;
        8'h21: idle_mode = ModeBang;
        8'h2B: begin idle_emit = 1'b1; idle_code = TokPlus;  end
        8'h2D: begin idle_emit = 1'b1; idle_code = TokMinus; end
        8'h2A: begin idle_emit = 1'b1; idle_code = TokMul;   end
        8'h2F: begin idle_emit = 1'b1; idle_code = TokDiv;   end
        8'h3B: begin idle_emit = 1'b1; idle_code = TokSemi;  end
        8'h28: begin idle_emit = 1'b1; idle_code = TokLpar;  end
        8'h29: begin idle_emit = 1'b1; idle_code = TokRpar;  end
        default: begin idle_emit = 1'b1; idle_code = TokError; end
      endcase
    end
  end

  always_comb begin
    idle_res.code  = idle_code;
    idle_res.len   = idle_len;
    idle_res.text  = eoi ? 64'd0 : {56'd0, c};
    idle_res.trunc = 1'b0;
    idle_res.last  = 1'b1;
  end

  // pending token and next scanner state
  always_comb begin
    pend_emit   = 1'b0;
    pend_rescan = 1'b1;
    do_append   = 1'b0;
    pend_res    = '0;
    unique case (mode_q)
      ModeWord, ModeNum: begin
        if (!eoi && (is_dg || (is_al && mode_q == ModeWord))) begin
          do_append   = 1'b1;
          pend_rescan = 1'b0;
        end else begin
          pend_emit      = 1'b1;
          pend_res.len   = 4'(count_q);
          pend_res.text  = packed_text;
          pend_res.trunc = ovf_q;
          if (mode_q == ModeNum) begin
            pend_res.code = TokNumber;
          end else begin
            pend_res.code = ovf_q ? TokIdent : kw_code(packed_text, 4'(count_q));
          end
        end
      end
      ModeColon, ModeLt, ModeGt, ModeEq, ModeBang: begin
        pend_emit = 1'b1;
        unique case (mode_q)
          ModeColon: pend_res.text = 64'h3A;
          ModeLt:    pend_res.text = 64'h3C;
          ModeGt:    pend_res.text = 64'h3E;
          ModeEq:    pend_res.text = 64'h3D;
          default:   pend_res.text = 64'h21;
        endcase
        if (!eoi && c == 8'h3D) begin
          pend_rescan      = 1'b0;
          pend_res.len     = 4'd2;
          pend_res.text[15:8] = 8'h3D;
          unique case (mode_q)
            ModeColon: pend_res.code = TokAssign;
            ModeLt:    pend_res.code = TokLe;
            ModeGt:    pend_res.code = TokGe;
            ModeEq:    pend_res.code = TokEq;
            default:   pend_res.code = TokNe;
          endcase
        end else begin
          pend_res.len = 4'd1;
          unique case (mode_q)
            ModeLt:  pend_res.code = TokLt;
            ModeGt:  pend_res.code = TokGt;
            default: pend_res.code = TokError;
          endcase
        end
      end
      default: begin
        pend_emit = 1'b0;
      end
    endcase
  end

  always_comb begin
    do_start = pend_rescan && idle_start;
    mode_d   = do_append ? mode_q : (pend_rescan ? idle_mode : ModeIdle);
    count_d  = count_q;
    ovf_d    = ovf_q;
    if (do_start) begin
      count_d = CntW'(1);
      ovf_d   = 1'b0;
    end else if (do_append) begin
      if (count_q < CntW'(MaxLen)) begin
        count_d = count_q + CntW'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  // up to two results per beat, the pending token first
  always_comb begin
    push_n = 2'd0;
    slot_a = idle_res;
    slot_b = idle_res;
    if (accept) begin
      if (pend_emit) begin
        slot_a      = pend_res;
        slot_a.last = !(pend_rescan && idle_emit);
        push_n      = (pend_rescan && idle_emit) ? 2'd2 : 2'd1;
      end else if (pend_rescan && idle_emit) begin
        push_n = 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeIdle;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else if (accept) begin
      mode_q  <= mode_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (do_start) begin
        store_q[0] <= c;
      end else if (do_append && count_q < CntW'(MaxLen)) begin
        store_q[count_q[IdxW-1:0]] <= c;
      end
    end
  end

  // result queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(push_n);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      fill_q <= fill_q + FillW'(push_n) - FillW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      queue_q[wr_ptr_q] <= slot_a;
    end
    if (push_n == 2'd2) begin
      queue_q[wr_ptr_q + PtrW'(1)] <= slot_b;
    end
  end

  assign s_axis_tready = (fill_q <= FillW'(QueueDepth - 2));
  assign m_axis_tvalid = (fill_q != '0);
  assign m_axis_tdata  = {6'd0, queue_q[rd_ptr_q].trunc, queue_q[rd_ptr_q].text,
                          queue_q[rd_ptr_q].len, queue_q[rd_ptr_q].code};
  assign m_axis_tlast  = queue_q[rd_ptr_q].last;

endmodule

@@ tb/keyword_lexer_unit_tb.sv @@
// keyword_lexer_unit_tb: self-checking bench for the streaming keyword lexer
// drives character beats, predicts tokens in-bench and checks every token beat
// depends on kwlex_pkg and keyword_lexer_unit
`timescale 1ns / 100ps

module keyword_lexer_unit_tb;
  import kwlex_pkg::*;

  localparam int LexMax = 8;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] char_code
  logic        s_axis_tuser;   // [0] end_of_input
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [79:0] m_axis_tdata;   // [4:0] token_code, [8:5] lexeme_length,
                               // [72:9] lexeme_text, [73] truncated, rest 0
  logic        m_axis_tlast;

  keyword_lexer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  string kw_names [12] = '{"start", "stop", "if", "then", "else", "end",
                           "while", "do", "for", "to", "read", "print"};
  string op_names [17] = '{":=", "<=", ">=", "==", "!=", "<", ">", "+", "-", "*",
                           "/", ";", "(", ")", ":", "=", "!"};

  // lexer shadow state
  scan_mode_e  lx_mode;
  logic [7:0]  lx_buf [LexMax];
  int          lx_cnt;
  logic        lx_ovf;

  result_t     step_toks [$];
  result_t     pending_tokens [$];
  int          mismatch_cnt;
  int          beats_sent;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_left;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_num(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic void add_tok(input logic [4:0] code, input logic [3:0] len,
                                  input logic [63:0] text, input logic trunc);
    result_t r;
    r.code  = code;
    r.len   = len;
    r.text  = text;
    r.trunc = trunc;
    r.last  = 1'b0;
    step_toks.push_back(r);
  endfunction

  function automatic void keep_char(input logic [7:0] c);
    if (lx_cnt < LexMax) begin
      lx_buf[lx_cnt] = c;
      lx_cnt++;
    end else begin
      lx_ovf = 1'b1;
    end
  endfunction

  function automatic logic [63:0] lexeme_bits();
    logic [63:0] t;
    t = '0;
    for (int i = 0; i < lx_cnt; i++) t[8*i +: 8] = lx_buf[i];
    return t;
  endfunction

  function automatic logic [4:0] word_token();
    logic [7:0] c;
    logic       hit;
    if (lx_ovf) return TokIdent;
    for (int k = 0; k < 12; k++) begin
      if (kw_names[k].len() == lx_cnt) begin
        hit = 1'b1;
        for (int i = 0; i < lx_cnt; i++) begin
          c = lx_buf[i];
          if (c >= "A" && c <= "Z") c = c + 8'd32;
          if (c != kw_names[k][i]) hit = 1'b0;
        end
        if (hit) return TokKwFirst + 5'(k);
      end
    end
    return TokIdent;
  endfunction

  // scan a byte with nothing pending
  function automatic void fresh_char(input logic [7:0] c, input logic eoi);
    if (eoi) begin
      add_tok(TokEnd, 4'd0, 64'd0, 1'b0);
    end else if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
    end else if (is_letter(c) || is_num(c)) begin
      lx_mode = is_letter(c) ? ModeWord : ModeNum;
      lx_cnt  = 0;
      lx_ovf  = 1'b0;
      keep_char(c);
    end else begin
      case (c)
        ":": lx_mode = ModeColon;
        "<": lx_mode = ModeLt;
        ">": lx_mode = ModeGt;
        "=": lx_mode = ModeEq;
        "!": lx_mode = ModeBang;
        "+": add_tok(TokPlus, 4'd1, 64'(c), 1'b0);
        "-": add_tok(TokMinus, 4'd1, 64'(c), 1'b0);
        "*": add_tok(TokMul, 4'd1, 64'(c), 1'b0);
        "/": add_tok(TokDiv, 4'd1, 64'(c), 1'b0);
        ";": add_tok(TokSemi, 4'd1, 64'(c), 1'b0);
        "(": add_tok(TokLpar, 4'd1, 64'(c), 1'b0);
        ")": add_tok(TokRpar, 4'd1, 64'(c), 1'b0);
        default: add_tok(TokError, 4'd1, 64'(c), 1'b0);
      endcase
    end
  endfunction

  // advance the shadow lexer by one accepted beat, queue the tokens it yields
  function automatic void predict_tokens(input logic [7:0] c, input logic eoi);
    scan_mode_e  was;
    logic [7:0]  op_ch;
    logic [4:0]  pair_code;
    logic [4:0]  single_code;
    was = lx_mode;
    lx_mode = ModeIdle;
    step_toks.delete();
    case (was)
      ModeIdle: fresh_char(c, eoi);
      ModeWord: begin
        if (!eoi && (is_letter(c) || is_num(c))) begin
          keep_char(c);
          lx_mode = ModeWord;
        end else begin
          add_tok(word_token(), 4'(lx_cnt), lexeme_bits(), lx_ovf);
          fresh_char(c, eoi);
        end
      end
      ModeNum: begin
        if (!eoi && is_num(c)) begin
          keep_char(c);
          lx_mode = ModeNum;
        end else begin
          add_tok(TokNumber, 4'(lx_cnt), lexeme_bits(), lx_ovf);
          fresh_char(c, eoi);
        end
      end
      default: begin
        case (was)
          ModeColon: begin op_ch = ":"; pair_code = TokAssign; single_code = TokError; end
          ModeLt:    begin op_ch = "<"; pair_code = TokLe;     single_code = TokLt;    end
          ModeGt:    begin op_ch = ">"; pair_code = TokGe;     single_code = TokGt;    end
          ModeEq:    begin op_ch = "="; pair_code = TokEq;     single_code = TokError; end
          default:   begin op_ch = "!"; pair_code = TokNe;     single_code = TokError; end
        endcase
        if (!eoi && c == "=") begin
          add_tok(pair_code, 4'd2, 64'({8'(c), op_ch}), 1'b0);
        end else begin
          add_tok(single_code, 4'd1, 64'(op_ch), 1'b0);
          fresh_char(c, eoi);
        end
      end
    endcase
    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
    foreach (step_toks[i]) pending_tokens.push_back(step_toks[i]);
  endfunction

  // entered just after a falling edge, returns at the falling edge after the beat
  task automatic send_beat(input logic [7:0] c, input logic eoi);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = c;
    s_axis_tuser  = eoi;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_tokens(c, eoi);
    beats_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] rand_letter();
    return ($urandom_range(1) ? "a" : "A") + 8'($urandom_range(25));
  endfunction

  function automatic logic [7:0] rand_space();
    return ($urandom_range(3) == 0) ? 8'($urandom_range(13, 9)) : " ";
  endfunction

  // one source fragment: keyword, identifier, number, operator, blank, noise or end
  task automatic send_fragment();
    logic [7:0] frag [$];
    int         pick;
    int         len;
    int         k;
    pick = $urandom_range(99);
    if (pick < 22) begin
      k = $urandom_range(11);
      for (int i = 0; i < kw_names[k].len(); i++)
        frag.push_back($urandom_range(1) ? kw_names[k][i] - 8'd32 : kw_names[k][i]);
      if ($urandom_range(7) == 0) frag.push_back(rand_letter());
    end else if (pick < 40) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(11, 7) : $urandom_range(4);
      frag.push_back(rand_letter());
      for (int i = 0; i < len; i++)
        frag.push_back($urandom_range(2) == 0 ? "0" + 8'($urandom_range(9)) : rand_letter());
    end else if (pick < 55) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(11, 7) : $urandom_range(4, 1);
      for (int i = 0; i < len; i++) frag.push_back("0" + 8'($urandom_range(9)));
    end else if (pick < 80) begin
      k = $urandom_range(16);
      for (int i = 0; i < op_names[k].len(); i++) frag.push_back(op_names[k][i]);
    end else if (pick < 90) begin
      frag.push_back(rand_space());
    end else if (pick < 96) begin
      frag.push_back(8'($urandom_range(255)));
    end
    if (pick >= 96) begin
      send_beat(8'($urandom_range(255)), 1'b1);
    end else begin
      foreach (frag[i]) send_beat(frag[i], 1'b0);
      if ($urandom_range(1)) send_beat(rand_space(), 1'b0);
    end
  endtask

  // let the token side run dry, then allow for the pipeline
  task automatic settle();
    int guard;
    guard = 0;
    s_axis_tvalid = 1'b0;
    while (pending_tokens.size() != 0 && guard < 20000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (6) @(negedge clk_i);
  endtask

  task automatic run_directed_text();
    string src;
    src = "ElSe x:=123456789!!=>=<";
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < src.len(); i++) send_beat(src[i], 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'hA5, 1'b1);
    settle();
  endtask

  task automatic run_random_text(input int idle_pct, input int stall_pct, input int n);
    int stop_at;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    stop_at = beats_sent + n;
    while (beats_sent < stop_at) send_fragment();
    settle();
  endtask

  // token side blocked for a long stretch while characters keep coming
  task automatic run_output_hold();
    int stop_at;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left = 120;
    stop_at = beats_sent + 60;
    while (beats_sent < stop_at) send_fragment();
    settle();
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        m_axis_tready = 1'b0;
        hold_left--;
      end else begin
        m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin : token_check
    result_t got;
    result_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        got.code  = m_axis_tdata[4:0];
        got.len   = m_axis_tdata[8:5];
        got.text  = m_axis_tdata[72:9];
        got.trunc = m_axis_tdata[73];
        got.last  = m_axis_tlast;
        if (pending_tokens.size() == 0) begin
          $display("%0t: unexpected token beat code %0d len %0d text %h trunc %b last %b",
                   $time, got.code, got.len, got.text, got.trunc, got.last);
          mismatch_cnt++;
        end else begin
          want = pending_tokens.pop_front();
          if (got !== want || m_axis_tdata[79:74] !== '0) begin
            $display("%0t: token mismatch expected code %0d len %0d text %h trunc %b last %b",
                     $time, want.code, want.len, want.text, want.trunc, want.last);
            $display("%0t:                actual code %0d len %0d text %h trunc %b last %b pad %h",
                     $time, got.code, got.len, got.text, got.trunc, got.last,
                     m_axis_tdata[79:74]);
            mismatch_cnt++;
          end
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("keyword_lexer_unit test failed");
    $finish;
  end

  initial begin
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = 1'b0;
    lx_mode        = ModeIdle;
    lx_cnt         = 0;
    lx_ovf         = 1'b0;
    mismatch_cnt   = 0;
    beats_sent     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    foreach (lx_buf[i]) lx_buf[i] = '0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    run_directed_text();
    run_random_text(0, 0, 150);
    run_random_text(56, 0, 150);
    run_random_text(0, 56, 150);
    run_random_text(29, 29, 150);
    run_output_hold();

    repeat (10) @(posedge clk_i);
    if (pending_tokens.size() != 0) begin
      $display("%0t: %0d expected tokens never arrived, next code %0d",
               $time, pending_tokens.size(), pending_tokens[0].code);
      mismatch_cnt++;
    end
    if (mismatch_cnt == 0) begin
      $display("keyword_lexer_unit test passed");
    end else begin
      $display("keyword_lexer_unit test failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/kwlex_pkg.sv
rtl/keyword_lexer_unit.sv
tb/keyword_lexer_unit_tb.sv
